### rtl/hdst_pkg.sv
// Shared types and constants for the five-point heat stencil unit.
// Used by every module in rtl/; depends on nothing else.
package hdst_pkg;

    // Field and register widths.
    localparam int DATA_W      = 32;
    localparam int FRAC_W      = 16;
    localparam int COEF_W      = 16;
    localparam int GRID_ROWS_W = 13;
    localparam int GRID_COLS_W = 9;
    localparam int CFG_W       = 16;
    localparam int CELL_ROW_W  = 12;
    localparam int CELL_COL_W  = 8;

    // Default grid limits and the smallest usable grid side.
    localparam int MAX_COLS_DEF = 256;
    localparam int MAX_ROWS_DEF = 4096;
    localparam int GRID_MIN     = 3;

    // Configuration reset values (coefficients are 0.1 in Q0.16).
    localparam logic [COEF_W-1:0]      COEF_X_RST    = 16'd6554;
    localparam logic [COEF_W-1:0]      COEF_Y_RST    = 16'd6554;
    localparam logic [GRID_ROWS_W-1:0] GRID_ROWS_RST = 13'd8;
    localparam logic [GRID_COLS_W-1:0] GRID_COLS_RST = 9'd12;

    // Arithmetic pipeline depth and result queue sizing.
    localparam int PIPE_STAGES = 3;
    localparam int FIFO_DEPTH  = 8;
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);
    localparam int INF_W       = $clog2(PIPE_STAGES + 2);

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_COEF_X    = 2'd0,
        CFG_COEF_Y    = 2'd1,
        CFG_GRID_ROWS = 2'd2,
        CFG_GRID_COLS = 2'd3
    } t_cfg_idx;

    // Which results a cell produces.
    typedef struct packed {
        logic int_cell;
        logic edge_cell;
    } t_emit;

endpackage

### rtl/hdst_line_store.sv
// Two line stores holding the previous row and the row before it.
// Synchronous memories with a registered read; uses hdst_pkg.
module hdst_line_store #(
    parameter int MAX_COLS = hdst_pkg::MAX_COLS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rd_en,
    input  logic [$clog2(MAX_COLS)-1:0]         i_rd_addr,
    input  logic                                i_wr_en,
    input  logic [$clog2(MAX_COLS)-1:0]         i_wr_addr,
    input  logic signed [hdst_pkg::DATA_W-1:0]  i_wr_prev,
    input  logic signed [hdst_pkg::DATA_W-1:0]  i_wr_older,
    output logic signed [hdst_pkg::DATA_W-1:0]  o_prev_c,
    output logic signed [hdst_pkg::DATA_W-1:0]  o_prev_n,
    output logic signed [hdst_pkg::DATA_W-1:0]  o_older_c
);
    import hdst_pkg::*;

    localparam int COL_W = $clog2(MAX_COLS);

    logic signed [DATA_W-1:0] r_prev  [MAX_COLS];
    logic signed [DATA_W-1:0] r_older [MAX_COLS];
    logic signed [DATA_W-1:0] r_rd_prev_c;
    logic signed [DATA_W-1:0] r_rd_prev_n;
    logic signed [DATA_W-1:0] r_rd_older_c;
    logic [COL_W-1:0]         w_addr_n;

    // The right-hand neighbour sits one column further on.
    assign w_addr_n = i_rd_addr + COL_W'(1);

    // Write port: the arriving cell into the previous row, its old centre one row up.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_prev[i_wr_addr]  <= i_wr_prev;
            r_older[i_wr_addr] <= i_wr_older;
        end
    end

    // Read ports: centre, right and up for the request being accepted.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_prev_c  <= r_prev[i_rd_addr];
            r_rd_prev_n  <= r_prev[w_addr_n];
            r_rd_older_c <= r_older[i_rd_addr];
        end
    end

    assign o_prev_c  = r_rd_prev_c;
    assign o_prev_n  = r_rd_prev_n;
    assign o_older_c = r_rd_older_c;

endmodule

### rtl/hdst_stencil_pipe.sv
// Three-stage arithmetic pipeline: differences, coefficient products,
// rounded sum, then saturation. Uses hdst_pkg.
module hdst_stencil_pipe #(
    parameter int MAX_COLS = hdst_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = hdst_pkg::MAX_ROWS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic signed [hdst_pkg::DATA_W-1:0]  i_up,
    input  logic signed [hdst_pkg::DATA_W-1:0]  i_down,
    input  logic signed [hdst_pkg::DATA_W-1:0]  i_left,
    input  logic signed [hdst_pkg::DATA_W-1:0]  i_right,
    input  logic signed [hdst_pkg::DATA_W-1:0]  i_centre,
    input  logic [hdst_pkg::COEF_W-1:0]         i_coef_x,
    input  logic [hdst_pkg::COEF_W-1:0]         i_coef_y,
    input  logic [$clog2(MAX_ROWS)-1:0]         i_row,
    input  logic [$clog2(MAX_COLS)-1:0]         i_col,
    input  hdst_pkg::t_emit                     i_emit,
    output logic [hdst_pkg::PIPE_STAGES-1:0]    o_stage_v,
    output logic                                o_push,
    output hdst_pkg::t_emit                     o_emit,
    output logic signed [hdst_pkg::DATA_W-1:0]  o_int_val,
    output logic signed [hdst_pkg::DATA_W-1:0]  o_temp,
    output logic [$clog2(MAX_ROWS)-1:0]         o_row,
    output logic [$clog2(MAX_COLS)-1:0]         o_col
);
    import hdst_pkg::*;

    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int DIFF_W = DATA_W + 2;
    localparam int PROD_W = DIFF_W + COEF_W + 1;
    localparam int ACC_W  = PROD_W + 2;
    localparam int Q_W    = ACC_W - FRAC_W;

    // Stage 1 registers.
    logic                     r_p1_v;
    logic signed [DIFF_W-1:0] r_p1_dv;
    logic signed [DIFF_W-1:0] r_p1_dh;
    logic signed [DATA_W-1:0] r_p1_centre;
    logic signed [DATA_W-1:0] r_p1_temp;
    logic [ROW_W-1:0]         r_p1_row;
    logic [COL_W-1:0]         r_p1_col;
    t_emit                    r_p1_emit;

    // Stage 2 registers.
    logic                     r_p2_v;
    logic signed [PROD_W-1:0] r_p2_pv;
    logic signed [PROD_W-1:0] r_p2_ph;
    logic signed [DATA_W-1:0] r_p2_centre;
    logic signed [DATA_W-1:0] r_p2_temp;
    logic [ROW_W-1:0]         r_p2_row;
    logic [COL_W-1:0]         r_p2_col;
    t_emit                    r_p2_emit;

    // Stage 3 registers.
    logic                     r_p3_v;
    logic signed [ACC_W-1:0]  r_p3_acc;
    logic signed [DATA_W-1:0] r_p3_temp;
    logic [ROW_W-1:0]         r_p3_row;
    logic [COL_W-1:0]         r_p3_col;
    t_emit                    r_p3_emit;

    logic signed [DIFF_W-1:0]  w_dv;
    logic signed [DIFF_W-1:0]  w_dh;
    logic signed [COEF_W:0]    w_cx;
    logic signed [COEF_W:0]    w_cy;
    logic signed [ACC_W-1:0]   w_acc;
    logic signed [Q_W-1:0]     w_q;
    logic [Q_W-DATA_W:0]       w_hi;

    // Second differences, formed exactly.
    always_comb begin
        w_dv = DIFF_W'(i_up) + DIFF_W'(i_down) - (DIFF_W'(i_centre) <<< 1);
        w_dh = DIFF_W'(i_left) + DIFF_W'(i_right) - (DIFF_W'(i_centre) <<< 1);
    end

    // Coefficients are unsigned; give them a zero sign bit.
    assign w_cx = $signed({1'b0, i_coef_x});
    assign w_cy = $signed({1'b0, i_coef_y});

    // Weighted sum plus centre in Q21.32, with the rounding half added.
    always_comb begin
        w_acc = ACC_W'(r_p2_pv) + ACC_W'(r_p2_ph)
              + (ACC_W'(r_p2_centre) <<< FRAC_W)
              + (ACC_W'(1) <<< (FRAC_W - 1));
    end

    // Valid bits of the three stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
        end else begin
            r_p1_v <= i_valid;
            r_p2_v <= r_p1_v;
            r_p3_v <= r_p2_v;
        end
    end

    // Payload of the three stages.
    always_ff @(posedge i_clk) begin
        r_p1_dv     <= w_dv;
        r_p1_dh     <= w_dh;
        r_p1_centre <= i_centre;
        r_p1_temp   <= i_down;
        r_p1_row    <= i_row;
        r_p1_col    <= i_col;
        r_p1_emit   <= i_emit;

        r_p2_pv     <= PROD_W'(r_p1_dv) * PROD_W'(w_cx);
        r_p2_ph     <= PROD_W'(r_p1_dh) * PROD_W'(w_cy);
        r_p2_centre <= r_p1_centre;
        r_p2_temp   <= r_p1_temp;
        r_p2_row    <= r_p1_row;
        r_p2_col    <= r_p1_col;
        r_p2_emit   <= r_p1_emit;

        r_p3_acc    <= w_acc;
        r_p3_temp   <= r_p2_temp;
        r_p3_row    <= r_p2_row;
        r_p3_col    <= r_p2_col;
        r_p3_emit   <= r_p2_emit;
    end

    // Drop the fraction (floor) and saturate to the 32-bit range.
    assign w_q  = r_p3_acc[ACC_W-1:FRAC_W];
    assign w_hi = w_q[Q_W-1:DATA_W-1];

    always_comb begin
        if ((&w_hi) || !(|w_hi)) begin
            o_int_val = w_q[DATA_W-1:0];
        end else if (w_hi[Q_W-DATA_W]) begin
            o_int_val = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            o_int_val = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    assign o_stage_v = {r_p3_v, r_p2_v, r_p1_v};
    assign o_push    = r_p3_v && (r_p3_emit.int_cell || r_p3_emit.edge_cell);
    assign o_emit    = r_p3_emit;
    assign o_temp    = r_p3_temp;
    assign o_row     = r_p3_row;
    assign o_col     = r_p3_col;

endmodule

### rtl/hdst_result_fifo.sv
// Result queue: one entry per cell holding up to two results, drained one
// result per output request, interior cell first. Uses hdst_pkg.
module hdst_result_fifo #(
    parameter int MAX_COLS = hdst_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = hdst_pkg::MAX_ROWS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_push,
    input  hdst_pkg::t_emit                      i_emit,
    input  logic signed [hdst_pkg::DATA_W-1:0]   i_int_val,
    input  logic signed [hdst_pkg::DATA_W-1:0]   i_temp,
    input  logic [$clog2(MAX_ROWS)-1:0]          i_row,
    input  logic [$clog2(MAX_COLS)-1:0]          i_col,
    output logic [hdst_pkg::CNT_W-1:0]           o_count,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [hdst_pkg::DATA_W-1:0]   o_new_temperature,
    output logic [hdst_pkg::CELL_ROW_W-1:0]      o_cell_row,
    output logic [hdst_pkg::CELL_COL_W-1:0]      o_cell_col,
    output logic                                 o_last_of_run
);
    import hdst_pkg::*;

    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int COL_W = $clog2(MAX_COLS);

    typedef struct packed {
        t_emit                    emit;
        logic signed [DATA_W-1:0] int_val;
        logic signed [DATA_W-1:0] temp;
        logic [ROW_W-1:0]         row;
        logic [COL_W-1:0]         col;
    } t_entry;

    t_entry                        r_buf [FIFO_DEPTH];
    logic [PTR_W-1:0]              r_wr_ptr;
    logic [PTR_W-1:0]              r_rd_ptr;
    logic [CNT_W-1:0]              r_count;
    logic                          r_phase;
    t_entry                        w_head;
    logic                          w_show_int;
    logic                          w_take;
    logic                          w_pop;
    logic [ROW_W-1:0]              w_row_sel;
    logic [ROW_W+CELL_ROW_W-1:0]   w_row_ext;
    logic [COL_W+CELL_COL_W-1:0]   w_col_ext;

    assign w_head     = r_buf[r_rd_ptr];
    assign o_valid    = (r_count != '0);
    assign w_show_int = w_head.emit.int_cell && !r_phase;
    assign w_take     = o_valid && i_ready;
    // The entry leaves once its last result is taken.
    assign w_pop      = w_take && !(w_show_int && w_head.emit.edge_cell);

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= '{emit: i_emit, int_val: i_int_val, temp: i_temp,
                                 row: i_row, col: i_col};
        end
    end

    // Pointers, fill count and the result phase within the head entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_phase  <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !w_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (w_take) begin
                r_phase <= !w_pop;
            end
        end
    end

    // Present the interior result of the row above first, then the edge cell.
    assign w_row_sel = w_show_int ? (w_head.row - ROW_W'(1)) : w_head.row;
    assign w_row_ext = (ROW_W + CELL_ROW_W)'(w_row_sel);
    assign w_col_ext = (COL_W + CELL_COL_W)'(w_head.col);

    assign o_new_temperature = w_show_int ? w_head.int_val : w_head.temp;
    assign o_cell_row        = w_row_ext[CELL_ROW_W-1:0];
    assign o_cell_col        = w_col_ext[CELL_COL_W-1:0];
    assign o_last_of_run     = !(w_show_int && w_head.emit.edge_cell);
    assign o_count           = r_count;

endmodule

### rtl/heat_diffusion_stencil_2d_unit.sv
// Five-point explicit heat stencil over a raster-ordered grid, signed Q16.16.
// Accepts one cell per cycle while o_in_ready is high. Output drains one result per cycle,
// while i_out_ready is high, from an 8-entry queue, and input is taken while queue fill
// plus cells in flight stays below the queue depth. Reset is synchronous: counters, window,
// queue and configuration return to defaults; the line stores keep their contents and are
// not cleared.
module heat_diffusion_stencil_2d_unit #(
    parameter int MAX_COLS = hdst_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = hdst_pkg::MAX_ROWS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  hdst_pkg::t_cfg_idx                  i_cfg_index,
    input  logic [hdst_pkg::CFG_W-1:0]          i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [hdst_pkg::DATA_W-1:0]  i_temperature,
    input  logic                                i_grid_start,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [hdst_pkg::DATA_W-1:0]  o_new_temperature,
    output logic [hdst_pkg::CELL_ROW_W-1:0]     o_cell_row,
    output logic [hdst_pkg::CELL_COL_W-1:0]     o_cell_col,
    output logic                                o_last_of_run
);
    import hdst_pkg::*;

    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int COL_W = $clog2(MAX_COLS);
    localparam int RC_W  = (ROW_W + 1 > GRID_ROWS_W) ? ROW_W + 1 : GRID_ROWS_W;
    localparam int CC_W  = (COL_W + 1 > GRID_COLS_W) ? COL_W + 1 : GRID_COLS_W;

    // Configuration registers.
    logic [COEF_W-1:0]      r_coef_x;
    logic [COEF_W-1:0]      r_coef_y;
    logic [GRID_ROWS_W-1:0] r_grid_rows;
    logic [GRID_COLS_W-1:0] r_grid_cols;

    // Position of the next arriving cell.
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] n_row;
    logic [COL_W-1:0] n_col;

    // Read stage: the accepted cell waiting for its line store data.
    logic                     r_s1_v;
    logic signed [DATA_W-1:0] r_s1_temp;
    logic [ROW_W-1:0]         r_s1_row;
    logic [COL_W-1:0]         r_s1_col;
    t_emit                    r_s1_emit;
    logic                     r_fwd_c;
    logic                     r_fwd_n;
    logic signed [DATA_W-1:0] r_fwd_temp;
    logic signed [DATA_W-1:0] r_fwd_centre;
    logic signed [DATA_W-1:0] r_left;

    logic [RC_W-1:0]  w_rows;
    logic [CC_W-1:0]  w_cols;
    logic [RC_W-1:0]  w_row0;
    logic [RC_W-1:0]  w_row1;
    logic [RC_W-1:0]  w_row2;
    logic [RC_W-1:0]  w_rowp;
    logic [CC_W-1:0]  w_col0;
    logic [CC_W-1:0]  w_col1;
    logic [CC_W-1:0]  w_colp;
    logic [ROW_W-1:0] w_r;
    logic [COL_W-1:0] w_c;
    logic [COL_W-1:0] w_c_n;
    t_emit            w_emit;
    logic             w_accept;

    logic signed [DATA_W-1:0] w_ls_prev_c;
    logic signed [DATA_W-1:0] w_ls_prev_n;
    logic signed [DATA_W-1:0] w_ls_older_c;
    logic signed [DATA_W-1:0] w_centre;
    logic signed [DATA_W-1:0] w_up;
    logic signed [DATA_W-1:0] w_right;

    logic [PIPE_STAGES-1:0]   w_stage_v;
    logic                     w_push;
    t_emit                    w_p_emit;
    logic signed [DATA_W-1:0] w_p_int_val;
    logic signed [DATA_W-1:0] w_p_temp;
    logic [ROW_W-1:0]         w_p_row;
    logic [COL_W-1:0]         w_p_col;
    logic [CNT_W-1:0]         w_fifo_count;
    logic [INF_W-1:0]         w_inflight;
    logic [CNT_W:0]           w_credit;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_x    <= COEF_X_RST;
            r_coef_y    <= COEF_Y_RST;
            r_grid_rows <= GRID_ROWS_RST;
            r_grid_cols <= GRID_COLS_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_COEF_X:    r_coef_x    <= COEF_W'(i_cfg_wdata);
                CFG_COEF_Y:    r_coef_y    <= COEF_W'(i_cfg_wdata);
                CFG_GRID_ROWS: r_grid_rows <= GRID_ROWS_W'(i_cfg_wdata);
                CFG_GRID_COLS: r_grid_cols <= GRID_COLS_W'(i_cfg_wdata);
            endcase
        end
    end

    // Grid size clamped to the supported range.
    always_comb begin
        w_rows = RC_W'(r_grid_rows);
        if (w_rows < RC_W'(GRID_MIN)) begin
            w_rows = RC_W'(GRID_MIN);
        end else if (w_rows > RC_W'(MAX_ROWS)) begin
            w_rows = RC_W'(MAX_ROWS);
        end
        w_cols = CC_W'(r_grid_cols);
        if (w_cols < CC_W'(GRID_MIN)) begin
            w_cols = CC_W'(GRID_MIN);
        end else if (w_cols > CC_W'(MAX_COLS)) begin
            w_cols = CC_W'(MAX_COLS);
        end
    end

    // Position of the arriving cell, its result flags and the position after it.
    always_comb begin
        w_row0 = i_grid_start ? '0 : RC_W'(r_row);
        w_col0 = i_grid_start ? '0 : CC_W'(r_col);
        if (w_col0 >= w_cols) begin
            w_col1 = '0;
            w_row1 = w_row0 + RC_W'(1);
        end else begin
            w_col1 = w_col0;
            w_row1 = w_row0;
        end
        w_row2 = (w_row1 >= w_rows) ? '0 : w_row1;
        w_r    = ROW_W'(w_row2);
        w_c    = COL_W'(w_col1);
        w_c_n  = w_c + COL_W'(1);

        w_emit.int_cell  = (w_row2 >= RC_W'(2)) && (w_col1 >= CC_W'(1))
                        && (w_col1 <= w_cols - CC_W'(2));
        w_emit.edge_cell = (w_row2 == '0) || (w_row2 == w_rows - RC_W'(1))
                        || (w_col1 == '0) || (w_col1 == w_cols - CC_W'(1));

        w_colp = w_col1 + CC_W'(1);
        w_rowp = w_row2;
        if (w_colp >= w_cols) begin
            w_colp = '0;
            w_rowp = w_row2 + RC_W'(1);
            if (w_rowp >= w_rows) begin
                w_rowp = '0;
            end
        end
        n_row = ROW_W'(w_rowp);
        n_col = COL_W'(w_colp);
    end

    // Credit: every cell in flight may still need one queue entry.
    always_comb begin
        w_inflight = INF_W'(r_s1_v);
        for (int k = 0; k < PIPE_STAGES; k++) begin
            w_inflight = w_inflight + INF_W'(w_stage_v[k]);
        end
        w_credit = (CNT_W + 1)'(w_fifo_count) + (CNT_W + 1)'(w_inflight);
    end

    assign o_in_ready = (w_credit < (CNT_W + 1)'(FIFO_DEPTH));
    assign w_accept   = i_in_valid && o_in_ready;

    // Position counters, read stage valid and the left neighbour.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_s1_v <= 1'b0;
            r_left <= '0;
        end else begin
            r_s1_v <= w_accept;
            if (w_accept) begin
                r_row <= n_row;
                r_col <= n_col;
            end
            // The centre of one cell is the left neighbour of the next.
            if (r_s1_v) begin
                r_left <= w_centre;
            end
        end
    end

    // Read stage payload, with forwarding of the write that lands on the same edge.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_temp    <= i_temperature;
            r_s1_row     <= w_r;
            r_s1_col     <= w_c;
            r_s1_emit    <= w_emit;
            r_fwd_c      <= r_s1_v && (r_s1_col == w_c);
            r_fwd_n      <= r_s1_v && (r_s1_col == w_c_n);
            r_fwd_temp   <= r_s1_temp;
            r_fwd_centre <= w_centre;
        end
    end

    assign w_centre = r_fwd_c ? r_fwd_temp   : w_ls_prev_c;
    assign w_up     = r_fwd_c ? r_fwd_centre : w_ls_older_c;
    assign w_right  = r_fwd_n ? r_fwd_temp   : w_ls_prev_n;

    hdst_line_store #(
        .MAX_COLS (MAX_COLS)
    ) u_line_store (
        .i_clk      (i_clk),
        .i_rd_en    (w_accept),
        .i_rd_addr  (w_c),
        .i_wr_en    (r_s1_v),
        .i_wr_addr  (r_s1_col),
        .i_wr_prev  (r_s1_temp),
        .i_wr_older (w_centre),
        .o_prev_c   (w_ls_prev_c),
        .o_prev_n   (w_ls_prev_n),
        .o_older_c  (w_ls_older_c)
    );

    hdst_stencil_pipe #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_stencil_pipe (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_s1_v),
        .i_up      (w_up),
        .i_down    (r_s1_temp),
        .i_left    (r_left),
        .i_right   (w_right),
        .i_centre  (w_centre),
        .i_coef_x  (r_coef_x),
        .i_coef_y  (r_coef_y),
        .i_row     (r_s1_row),
        .i_col     (r_s1_col),
        .i_emit    (r_s1_emit),
        .o_stage_v (w_stage_v),
        .o_push    (w_push),
        .o_emit    (w_p_emit),
        .o_int_val (w_p_int_val),
        .o_temp    (w_p_temp),
        .o_row     (w_p_row),
        .o_col     (w_p_col)
    );

    hdst_result_fifo #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_result_fifo (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (w_push),
        .i_emit            (w_p_emit),
        .i_int_val         (w_p_int_val),
        .i_temp            (w_p_temp),
        .i_row             (w_p_row),
        .i_col             (w_p_col),
        .o_count           (w_fifo_count),
        .o_valid           (o_out_valid),
        .i_ready           (i_out_ready),
        .o_new_temperature (o_new_temperature),
        .o_cell_row        (o_cell_row),
        .o_cell_col        (o_cell_col),
        .o_last_of_run     (o_last_of_run)
    );

    // The credit scheme must leave room for every result entry.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (w_fifo_count < CNT_W'(FIFO_DEPTH)))
        else $error("result queue written while full");

    // A cell in the read stage enters the arithmetic pipeline on the next edge.
    a_pipe_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stage_v[0] == $past(r_s1_v && i_rst_n))
        else $error("read stage and arithmetic pipeline out of step");

    // After an interior result comes the edge cell one row below, same column.
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last_of_run) |=>
        (o_out_valid && (o_cell_row == $past(o_cell_row) + CELL_ROW_W'(1))
         && (o_cell_col == $past(o_cell_col))))
        else $error("second result of a cell out of order");

endmodule

### sim/heat_diffusion_stencil_2d_unit_test.sv
// Self-checking bench for the five-point heat stencil unit: random and directed grids,
// a scoreboard class that predicts every emitted cell, and handshake stalls on both sides.
// Depends on rtl/hdst_pkg.sv and rtl/heat_diffusion_stencil_2d_unit.sv with its submodules.
`timescale 1ns / 100ps

module heat_diffusion_stencil_2d_unit_test;
    import hdst_pkg::*;

    localparam int     RESET_CYCLES  = 10;
    localparam int     SETTLE_CYCLES = 20;
    localparam int     DRAIN_LIMIT   = 20000;
    localparam int     TIMEOUT_NS    = 3000000;
    localparam longint SAT_HI        = 64'sd2147483647;
    localparam longint SAT_LO        = -64'sd2147483648;
    localparam logic [DATA_W-1:0] T_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] T_MIN = 32'h8000_0000;

    // One emitted cell as it leaves the block.
    typedef struct packed {
        logic [DATA_W-1:0]     temp;
        logic [CELL_ROW_W-1:0] row;
        logic [CELL_COL_W-1:0] col;
        logic                  last;
    } t_cell_result;

    // Tracks the grid position, the line stores and the cells still owed by the block.
    class stencil_board;
        logic [DATA_W-1:0]      prev_row [MAX_COLS_DEF];
        logic [DATA_W-1:0]      older_row [MAX_COLS_DEF];
        logic [DATA_W-1:0]      left_reg;
        int unsigned            row_pos;
        int unsigned            col_pos;
        logic [COEF_W-1:0]      coef_x;
        logic [COEF_W-1:0]      coef_y;
        logic [GRID_ROWS_W-1:0] grid_rows;
        logic [GRID_COLS_W-1:0] grid_cols;
        t_cell_result           pending_cells [$];
        int                     mismatches;
        int                     cells_noted;
        int                     results_checked;

        function new();
            foreach (prev_row[k]) begin
                prev_row[k]  = '0;
                older_row[k] = '0;
            end
            left_reg        = '0;
            row_pos         = 0;
            col_pos         = 0;
            coef_x          = COEF_X_RST;
            coef_y          = COEF_Y_RST;
            grid_rows       = GRID_ROWS_RST;
            grid_cols       = GRID_COLS_RST;
            mismatches      = 0;
            cells_noted     = 0;
            results_checked = 0;
        endfunction

        function void apply_reg(t_cfg_idx idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_COEF_X:    coef_x = val[COEF_W-1:0];
                CFG_COEF_Y:    coef_y = val[COEF_W-1:0];
                CFG_GRID_ROWS: grid_rows = val[GRID_ROWS_W-1:0];
                CFG_GRID_COLS: grid_cols = val[GRID_COLS_W-1:0];
                default: ;
            endcase
        endfunction

        // Sizes outside the supported range are clamped.
        function int unsigned rows_in_use();
            if (grid_rows < GRID_MIN) return GRID_MIN;
            if (grid_rows > MAX_ROWS_DEF) return MAX_ROWS_DEF;
            return grid_rows;
        endfunction

        function int unsigned cols_in_use();
            if (grid_cols < GRID_MIN) return GRID_MIN;
            if (grid_cols > MAX_COLS_DEF) return MAX_COLS_DEF;
            return grid_cols;
        endfunction

        function int unsigned grid_area();
            return rows_in_use() * cols_in_use();
        endfunction

        function int pending();
            return pending_cells.size();
        endfunction

        // Weighted differences in Q32.32, rounded to nearest (ties upward), then saturated.
        function logic [DATA_W-1:0] relax(logic [DATA_W-1:0] up, down, left, right, centre);
            longint c;
            longint dv;
            longint dh;
            longint acc;
            longint r;
            c   = longint'($signed(centre));
            dv  = longint'($signed(up)) + longint'($signed(down)) - 2 * c;
            dh  = longint'($signed(left)) + longint'($signed(right)) - 2 * c;
            acc = dv * longint'(coef_x) + dh * longint'(coef_y) + c * 65536;
            r   = (acc + 32768) >>> 16;
            if (r > SAT_HI) r = SAT_HI;
            if (r < SAT_LO) r = SAT_LO;
            return r[DATA_W-1:0];
        endfunction

        // Advances the grid by one accepted cell and queues the cells it releases.
        function void note_cell(logic [DATA_W-1:0] temp, logic start);
            int unsigned       n_rows;
            int unsigned       n_cols;
            logic [DATA_W-1:0] centre;
            logic [DATA_W-1:0] up;
            logic [DATA_W-1:0] right;
            logic              interior;
            logic              border;
            n_rows = rows_in_use();
            n_cols = cols_in_use();
            cells_noted++;
            if (start) begin
                row_pos = 0;
                col_pos = 0;
            end
            // Counts left beyond a size that shrank are wrapped first.
            if (col_pos >= n_cols) begin
                col_pos = 0;
                row_pos++;
            end
            if (row_pos >= n_rows) row_pos = 0;

            centre   = prev_row[col_pos];
            up       = older_row[col_pos];
            right    = (col_pos + 1 < MAX_COLS_DEF) ? prev_row[col_pos + 1] : '0;
            interior = row_pos >= 2 && col_pos >= 1 && col_pos <= n_cols - 2;
            border   = row_pos == 0 || row_pos == n_rows - 1 ||
                       col_pos == 0 || col_pos == n_cols - 1;

            // The interior cell of the row above leaves before the arriving edge cell.
            if (interior)
                pending_cells.push_back('{relax(up, temp, left_reg, right, centre),
                                          CELL_ROW_W'(row_pos - 1), CELL_COL_W'(col_pos),
                                          !border});
            if (border)
                pending_cells.push_back('{temp, CELL_ROW_W'(row_pos), CELL_COL_W'(col_pos),
                                          1'b1});

            left_reg           = centre;
            older_row[col_pos] = centre;
            prev_row[col_pos]  = temp;

            col_pos++;
            if (col_pos >= n_cols) begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= n_rows) row_pos = 0;
            end
        endfunction

        function void check_result(logic [DATA_W-1:0] temp, logic [CELL_ROW_W-1:0] row,
                                   logic [CELL_COL_W-1:0] col, logic last);
            t_cell_result owed;
            if (pending_cells.size() == 0) begin
                $error("cell (%0d,%0d) emitted with no request outstanding", row, col);
                mismatches++;
                return;
            end
            owed = pending_cells.pop_front();
            results_checked++;
            if (temp !== owed.temp) begin
                $error("new_temperature: expected %0d, got %0d",
                       $signed(owed.temp), $signed(temp));
                mismatches++;
            end
            if (row !== owed.row) begin
                $error("cell_row: expected %0d, got %0d", owed.row, row);
                mismatches++;
            end
            if (col !== owed.col) begin
                $error("cell_col: expected %0d, got %0d", owed.col, col);
                mismatches++;
            end
            if (last !== owed.last) begin
                $error("last_of_run: expected %0b, got %0b", owed.last, last);
                mismatches++;
            end
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_wr_en = 1'b0;
    t_cfg_idx                 i_cfg_index = CFG_COEF_X;
    logic [CFG_W-1:0]         i_cfg_wdata = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic signed [DATA_W-1:0] i_temperature = '0;
    logic                     i_grid_start = 1'b0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic signed [DATA_W-1:0] o_new_temperature;
    logic [CELL_ROW_W-1:0]    o_cell_row;
    logic [CELL_COL_W-1:0]    o_cell_col;
    logic                     o_last_of_run;

    stencil_board      board;
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                drain_hold = 0;
    int                settings_run = 0;
    logic [DATA_W-1:0] probe_cells [12];

    heat_diffusion_stencil_2d_unit u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_temperature     (i_temperature),
        .i_grid_start      (i_grid_start),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_new_temperature (o_new_temperature),
        .o_cell_row        (o_cell_row),
        .o_cell_col        (o_cell_col),
        .o_last_of_run     (o_last_of_run)
    );

    always #6 i_clk = ~i_clk;

    // Mostly small values close together, with the extremes and full-range noise mixed in.
    function automatic logic [DATA_W-1:0] rand_temp();
        logic signed [DATA_W-1:0] near;
        near = $urandom_range(2097151);
        case ($urandom_range(9))
            0:       return T_MAX;
            1:       return T_MIN;
            2, 3:    return $urandom();
            default: return near - 32'sd1048576;
        endcase
    endfunction

    task automatic put_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        board.apply_reg(idx, val);
    endtask

    // Writes all four registers on consecutive cycles; the block must be idle.
    task automatic load_settings(input logic [CFG_W-1:0] cx, cy, rows, cols);
        i_cfg_wr_en <= 1'b1;
        put_reg(CFG_COEF_X, cx);
        put_reg(CFG_COEF_Y, cy);
        put_reg(CFG_GRID_ROWS, rows);
        put_reg(CFG_GRID_COLS, cols);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Offers one cell, idling beforehand at random, and waits for its request to be taken.
    task automatic send_cell(input logic [DATA_W-1:0] temp, input logic start);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid    <= 1'b1;
        i_temperature <= temp;
        i_grid_start  <= start;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.note_cell(temp, start);
    endtask

    // Waits for every owed cell, then lets any cell with no result leave the pipeline.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Whole grids with random content; grid_start is sometimes left to the count wrap,
    // and now and then a stray one breaks a grid early.
    task automatic run_phase(input logic [CFG_W-1:0] cx, cy, rows, cols,
                             input int count, input int hold);
        int   pos;
        int   area;
        logic start;
        settle();
        load_settings(cx, cy, rows, cols);
        if (hold > 0) drain_hold = hold;
        area = board.grid_area();
        pos  = 0;
        for (int k = 0; k < count; k++) begin
            start = (k == 0) || (pos == 0 && $urandom_range(1) == 1) ||
                    ($urandom_range(99) < 3);
            if (start) pos = 0;
            send_cell(rand_temp(), start);
            pos = (pos + 1) % area;
        end
        settings_run++;
    endtask

    // Result side: checks each accepted result and stalls at random or for a long hold.
    initial begin : drain
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && i_out_ready && o_out_valid)
                board.check_result(o_new_temperature, o_cell_row, o_cell_col, o_last_of_run);
            if (drain_hold > 0) begin
                hold_left  = drain_hold;
                drain_hold = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin : stimulus
        int drain_wait;
        board = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Three-by-four grid, largest coefficients: one interior cell saturates high, one low.
        send_idle_pct = 12;
        recv_idle_pct = 68;
        probe_cells = '{32'h0, T_MAX, T_MIN, 32'hFFFF_FFFF,
                        T_MIN, T_MIN, T_MAX, T_MIN,
                        32'h1, T_MAX, T_MIN, 32'h0};
        load_settings(16'hFFFF, 16'hFFFF, 16'd3, 16'd4);
        foreach (probe_cells[k]) send_cell(probe_cells[k], k == 0);

        // Half a vertical weight makes rounding ties common; the columns then shrink
        // mid-grid so the column count has to wrap before the next cell is placed.
        settle();
        load_settings(16'h8000, 16'h0000, 16'd5, 16'd5);
        for (int k = 0; k < 13; k++) send_cell(rand_temp(), k == 0);
        settle();
        load_settings(16'h8000, 16'h0000, 16'd5, 16'd3);
        repeat (3) send_cell(rand_temp(), 1'b0);

        run_phase(16'd6554, 16'd6554, 16'd8, 16'd12, 96, 0);
        run_phase(16'd0, 16'd0, 16'd4, 16'd5, 40, 0);
        run_phase(16'hFFFF, 16'hFFFF, 16'd3, 16'd3, 27, 0);

        send_idle_pct = 68;
        recv_idle_pct = 12;
        run_phase(16'h8000, 16'd0, 16'd6, 16'd7, 84, 0);
        run_phase(16'd1, 16'hFFFF, 16'd5, 16'd4, 40, 0);
        run_phase(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                  16'd1, 16'd0, 18, 0);

        // Tallest and widest grids; the wide one starts behind a long output stall.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                  16'd4096, 16'd3, 45, 0);
        run_phase(16'd6554, 16'd13107, 16'd3, 16'd511, 322, 400);

        i_in_valid <= 1'b0;
        drain_wait = 0;
        while (board.pending() != 0 && drain_wait < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_wait++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (board.pending() != 0) begin
            $error("%0d expected cells never emitted", board.pending());
            board.mismatches++;
        end

        $display("Checked %0d emitted cells from %0d accepted cells over %0d random settings,",
                 board.results_checked, board.cells_noted, settings_run);
        $display("including saturation, rounding ties, mid-grid resizing and a long stall.");
        if (board.mismatches == 0)
            $display("heat_diffusion_stencil_2d_unit verification clean");
        else
            $display("heat_diffusion_stencil_2d_unit verification failed");
        $finish;
    end

    // Guard against a hung handshake.
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("heat_diffusion_stencil_2d_unit verification failed");
        $finish;
    end

endmodule

### filelist.f
rtl/hdst_pkg.sv
rtl/hdst_line_store.sv
rtl/hdst_stencil_pipe.sv
rtl/hdst_result_fifo.sv
rtl/heat_diffusion_stencil_2d_unit.sv
sim/heat_diffusion_stencil_2d_unit_test.sv
